// File: hw/rtl/tcpoks_pkg.sv
package tcpoks_pkg;

    localparam int MAX_OPTION_BYTES  = 40;
    localparam int MIN_OPTION_LENGTH = 2;

    localparam logic [7:0] KIND_END = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;

    localparam logic [7:0] PRIMARY_KIND_RESET   = 8'd254;
    localparam logic [7:0] SECONDARY_KIND_RESET = 8'd253;

    localparam int CFG_ADDR_W = 3;

    typedef enum logic [1:0] {
        OUTCOME_MATCH     = 2'd0,
        OUTCOME_END       = 2'd1,
        OUTCOME_MALFORMED = 2'd2,
        OUTCOME_EXHAUSTED = 2'd3
    } t_outcome;

    typedef enum logic {
        REG_PRIMARY_KIND   = 1'b0,
        REG_SECONDARY_KIND = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [7:0] primary_kind;
        logic [7:0] secondary_kind;
    } t_cfg;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       first_byte;
        logic [7:0] area_length;
        logic       final_byte;
    } t_item;

    typedef struct packed {
        logic       found;
        logic [5:0] match_offset;
        logic [7:0] match_kind;
        t_outcome   outcome;
    } t_result;

    function automatic t_result make_result(t_outcome outcome, logic [5:0] offset,
                                            logic [7:0] kind);
        t_result res;
        res.found        = (outcome == OUTCOME_MATCH);
        res.match_offset = offset;
        res.match_kind   = kind;
        res.outcome      = outcome;
        return res;
    endfunction

endpackage

// File: hw/rtl/tcpoks_cfg.sv
module tcpoks_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcpoks_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output tcpoks_pkg::t_cfg                    o_cfg
);

    tcpoks_pkg::t_cfg   r_cfg;
    tcpoks_pkg::t_cfg   n_cfg;
    logic               w_write;
    tcpoks_pkg::t_reg_index w_index;

    assign pready  = 1'b1;
    assign w_write = psel & penable & pwrite & pready;
    assign w_index = tcpoks_pkg::t_reg_index'(paddr[2]);

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_index)
                tcpoks_pkg::REG_PRIMARY_KIND:   n_cfg.primary_kind   = pwdata[7:0];
                tcpoks_pkg::REG_SECONDARY_KIND: n_cfg.secondary_kind = pwdata[7:0];
                default:                        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.primary_kind   <= tcpoks_pkg::PRIMARY_KIND_RESET;
            r_cfg.secondary_kind <= tcpoks_pkg::SECONDARY_KIND_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_index)
            tcpoks_pkg::REG_PRIMARY_KIND:   prdata = {24'd0, r_cfg.primary_kind};
            tcpoks_pkg::REG_SECONDARY_KIND: prdata = {24'd0, r_cfg.secondary_kind};
            default:                        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/tcpoks_walker.sv
module tcpoks_walker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcpoks_pkg::t_cfg      i_cfg,
    input  logic                  i_valid,
    input  tcpoks_pkg::t_item     i_item,
    output logic                  o_res_valid,
    output tcpoks_pkg::t_result   o_res
);

    logic       r_searching;
    logic [5:0] r_byte_position;
    logic [5:0] r_bytes_to_skip;
    logic [7:0] r_held_kind;
    logic       r_awaiting_length;
    logic [5:0] r_clamped_length;

    logic       n_searching;
    logic [5:0] n_byte_position;
    logic [5:0] n_bytes_to_skip;
    logic [7:0] n_held_kind;
    logic       n_awaiting_length;
    logic [5:0] n_clamped_length;

    logic [5:0] w_clamp;
    logic [5:0] w_kind_pos;
    logic [5:0] w_room;
    logic [6:0] w_pos_inc;
    logic [7:0] w_skip_full;
    logic       w_done;

    assign w_clamp = (i_item.area_length < 8'(tcpoks_pkg::MAX_OPTION_BYTES))
                   ? i_item.area_length[5:0] : 6'(tcpoks_pkg::MAX_OPTION_BYTES);

    always_comb begin
        n_searching       = r_searching;
        n_byte_position   = r_byte_position;
        n_bytes_to_skip   = r_bytes_to_skip;
        n_held_kind       = r_held_kind;
        n_awaiting_length = r_awaiting_length;
        n_clamped_length  = r_clamped_length;
        o_res_valid       = 1'b0;
        o_res             = tcpoks_pkg::make_result(tcpoks_pkg::OUTCOME_EXHAUSTED, 6'd0, 8'd0);
        w_done            = 1'b0;
        w_kind_pos        = 6'd0;
        w_room            = 6'd0;
        w_pos_inc         = 7'd0;
        w_skip_full       = 8'd0;

        // new header restarts the walk
        if (i_item.first_byte) begin
            n_searching       = 1'b1;
            n_byte_position   = 6'd0;
            n_bytes_to_skip   = 6'd0;
            n_held_kind       = 8'd0;
            n_awaiting_length = 1'b0;
            n_clamped_length  = w_clamp;
            if (w_clamp == 6'd0) begin
                o_res_valid = 1'b1;
                w_done      = 1'b1;
            end
        end
        if (!w_done && !n_searching) begin
            w_done = 1'b1;
        end

        if (!w_done) begin
            if (n_bytes_to_skip != 6'd0) begin
                n_bytes_to_skip = n_bytes_to_skip - 6'd1;
            end else if (n_awaiting_length) begin
                w_kind_pos = (n_byte_position != 6'd0) ? n_byte_position - 6'd1 : 6'd0;
                w_room     = (n_clamped_length > w_kind_pos)
                           ? n_clamped_length - w_kind_pos : 6'd0;
                n_awaiting_length = 1'b0;
                if (i_item.option_byte < 8'(tcpoks_pkg::MIN_OPTION_LENGTH)
                    || i_item.option_byte > {2'd0, w_room}) begin
                    o_res_valid = 1'b1;
                    o_res = tcpoks_pkg::make_result(tcpoks_pkg::OUTCOME_MALFORMED,
                                                    6'd0, 8'd0);
                    w_done = 1'b1;
                end else if (n_held_kind == i_cfg.primary_kind
                             || n_held_kind == i_cfg.secondary_kind) begin
                    o_res_valid = 1'b1;
                    o_res = tcpoks_pkg::make_result(tcpoks_pkg::OUTCOME_MATCH,
                                                    w_kind_pos, n_held_kind);
                    w_done = 1'b1;
                end else begin
                    w_skip_full     = i_item.option_byte
                                    - 8'(tcpoks_pkg::MIN_OPTION_LENGTH);
                    n_bytes_to_skip = w_skip_full[5:0];
                end
            end else begin
                if (i_item.final_byte) begin
                    o_res_valid = 1'b1;
                    w_done      = 1'b1;
                end else if (i_item.option_byte == tcpoks_pkg::KIND_END) begin
                    o_res_valid = 1'b1;
                    o_res = tcpoks_pkg::make_result(tcpoks_pkg::OUTCOME_END, 6'd0, 8'd0);
                    w_done = 1'b1;
                end else if (i_item.option_byte != tcpoks_pkg::KIND_NOP) begin
                    if ({1'b0, n_clamped_length}
                        < {1'b0, n_byte_position} + 7'(tcpoks_pkg::MIN_OPTION_LENGTH)) begin
                        o_res_valid = 1'b1;
                        o_res = tcpoks_pkg::make_result(tcpoks_pkg::OUTCOME_MALFORMED,
                                                        6'd0, 8'd0);
                        w_done = 1'b1;
                    end else begin
                        n_held_kind       = i_item.option_byte;
                        n_awaiting_length = 1'b1;
                    end
                end
            end

            if (!w_done) begin
                w_pos_inc       = {1'b0, n_byte_position} + 7'd1;
                n_byte_position = w_pos_inc[5:0];
                if (w_pos_inc >= {1'b0, n_clamped_length} || i_item.final_byte) begin
                    o_res_valid = 1'b1;
                end
            end
        end

        // any result closes the search
        if (o_res_valid) begin
            n_searching       = 1'b0;
            n_awaiting_length = 1'b0;
            n_bytes_to_skip   = 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_searching       <= 1'b0;
            r_byte_position   <= 6'd0;
            r_bytes_to_skip   <= 6'd0;
            r_held_kind       <= 8'd0;
            r_awaiting_length <= 1'b0;
            r_clamped_length  <= 6'd0;
        end else if (i_valid) begin
            r_searching       <= n_searching;
            r_byte_position   <= n_byte_position;
            r_bytes_to_skip   <= n_bytes_to_skip;
            r_held_kind       <= n_held_kind;
            r_awaiting_length <= n_awaiting_length;
            r_clamped_length  <= n_clamped_length;
        end
    end

    a_result_closes_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_res_valid) |=> !r_searching)
        else $error("search still open after a result");

    a_position_inside_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_searching |-> (r_byte_position < r_clamped_length))
        else $error("byte position past the option area");

    a_found_kind_searched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_res_valid && o_res.found)
            |-> (o_res.match_kind == i_cfg.primary_kind
                 || o_res.match_kind == i_cfg.secondary_kind))
        else $error("match reported for a kind not searched for");

    a_found_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_res_valid && o_res.found)
            |-> (o_res.match_offset < 6'(tcpoks_pkg::MAX_OPTION_BYTES)))
        else $error("match offset outside the option area");

endmodule

// File: hw/rtl/tcp_option_kind_search.sv
// Walks the TCP option area one byte per request and reports, once per header, the first
// option whose kind equals primary_kind or secondary_kind, or why the walk stopped (end of
// list, malformed length, area or data used up). A byte is taken every cycle unless the result
// side stalls: each request is registered, examined combinationally against the walk state,
// and the result lands in an output register; a stalled result holds back new requests
// only while both registers are full. s_axis_tuser marks the first byte of a header,
// s_axis_tlast the last byte available. A header's result appears on the byte that
// decides it; bytes after that, up to the next first byte, are dropped. Register 0 (byte
// address 0) is primary_kind, reset 254; register 1 (byte address 4) is secondary_kind,
// reset 253; write them only while no header is in flight.
module tcp_option_kind_search (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // option_byte, area_length
    input  logic                                s_axis_tuser,  // first_byte
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // found, match_offset, match_kind, outcome, zero fill
    output logic [23:0]                         m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tcpoks_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    tcpoks_pkg::t_cfg       w_cfg;
    logic                   r_in_valid;
    tcpoks_pkg::t_item      r_in;
    logic                   r_out_valid;
    tcpoks_pkg::t_result    r_out;
    logic                   w_advance;
    logic                   w_res_valid;
    tcpoks_pkg::t_result    w_res;

    tcpoks_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance     = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.option_byte <= s_axis_tdata[7:0];
            r_in.area_length <= s_axis_tdata[15:8];
            r_in.first_byte  <= s_axis_tuser;
            r_in.final_byte  <= s_axis_tlast;
        end
    end

    tcpoks_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_advance),
        .i_item      (r_in),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.outcome, r_out.match_kind,
                            r_out.match_offset, r_out.found};

endmodule

// File: bench/tcp_option_kind_search_checker.sv
module tcp_option_kind_search_checker
    import tcpoks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [15:0]           i_in_data,   // option_byte, area_length
    input  logic                  i_in_first,  // first_byte
    input  logic                  i_in_final,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [23:0]           i_out_data,  // found, match_offset, match_kind, outcome, fill
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_pending,
    output int                    o_errors
);

    localparam int REPORT_LIMIT = 10;

    logic [7:0] cfg_primary;
    logic [7:0] cfg_secondary;

    logic       walk_open;
    logic [5:0] walk_pos;
    logic [7:0] skip_left;
    logic [7:0] pending_kind;
    logic       want_length;
    logic [5:0] area_span;

    t_result     expected_results[$];
    int unsigned failures;

    function automatic t_result close_walk(t_outcome oc, int unsigned offset, logic [7:0] kind);
        t_result res;
        res.found        = (oc == OUTCOME_MATCH);
        res.match_offset = 6'(offset);
        res.match_kind   = kind;
        res.outcome      = oc;
        walk_open   = 1'b0;
        want_length = 1'b0;
        skip_left   = '0;
        return res;
    endfunction

    function automatic bit walk_option_byte(input logic [7:0] b, input logic first,
                                            input logic [7:0] area, input logic fin,
                                            output t_result res);
        int unsigned pos;
        int unsigned kind_pos;
        int unsigned room;
        res = '0;
        if (first) begin
            walk_open    = 1'b1;
            walk_pos     = '0;
            skip_left    = '0;
            pending_kind = '0;
            want_length  = 1'b0;
            area_span    = (area < MAX_OPTION_BYTES) ? 6'(area) : 6'(MAX_OPTION_BYTES);
            if (area_span == 0) begin
                res = close_walk(OUTCOME_EXHAUSTED, 0, '0);
                return 1'b1;
            end
        end
        if (!walk_open)
            return 1'b0;

        pos = walk_pos;
        if (skip_left > 0) begin
            skip_left = skip_left - 8'd1;
        end else if (want_length) begin
            kind_pos    = (pos > 0) ? pos - 1 : 0;
            room        = (area_span > kind_pos) ? area_span - kind_pos : 0;
            want_length = 1'b0;
            if (b < MIN_OPTION_LENGTH || b > room) begin
                res = close_walk(OUTCOME_MALFORMED, 0, '0);
                return 1'b1;
            end
            if (pending_kind == cfg_primary || pending_kind == cfg_secondary) begin
                res = close_walk(OUTCOME_MATCH, kind_pos, pending_kind);
                return 1'b1;
            end
            skip_left = b - 8'(MIN_OPTION_LENGTH);
        end else begin
            if (fin) begin
                res = close_walk(OUTCOME_EXHAUSTED, 0, '0);
                return 1'b1;
            end
            if (b == KIND_END) begin
                res = close_walk(OUTCOME_END, 0, '0);
                return 1'b1;
            end
            if (b != KIND_NOP) begin
                if (area_span < pos + MIN_OPTION_LENGTH) begin
                    res = close_walk(OUTCOME_MALFORMED, 0, '0);
                    return 1'b1;
                end
                pending_kind = b;
                want_length  = 1'b1;
            end
        end

        pos      = pos + 1;
        walk_pos = 6'(pos);
        if (pos >= area_span || fin) begin
            res = close_walk(OUTCOME_EXHAUSTED, 0, '0);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_result expected;
        t_result observed;
        if (!i_rst_n) begin
            cfg_primary   = PRIMARY_KIND_RESET;
            cfg_secondary = SECONDARY_KIND_RESET;
            walk_open     = 1'b0;
            walk_pos      = '0;
            skip_left     = '0;
            pending_kind  = '0;
            want_length   = 1'b0;
            area_span     = '0;
            failures      = 0;
            expected_results.delete();
            o_pending <= 0;
            o_errors  <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (t_reg_index'(i_paddr[2]) == REG_PRIMARY_KIND)
                    cfg_primary = i_pwdata[7:0];
                else
                    cfg_secondary = i_pwdata[7:0];
            end

            if (i_out_valid && i_out_ready) begin
                observed.found        = i_out_data[0];
                observed.match_offset = i_out_data[6:1];
                observed.match_kind   = i_out_data[14:7];
                observed.outcome      = t_outcome'(i_out_data[16:15]);
                if (expected_results.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result: found=%0d offset=%0d kind=%0d outcome=%0d",
                                 observed.found, observed.match_offset, observed.match_kind,
                                 observed.outcome);
                end else begin
                    expected = expected_results.pop_front();
                    if (observed.found !== expected.found ||
                        observed.match_offset !== expected.match_offset ||
                        observed.match_kind !== expected.match_kind ||
                        observed.outcome !== expected.outcome) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $write("result mismatch: expected found=%0d offset=%0d kind=%0d",
                                   expected.found, expected.match_offset, expected.match_kind);
                            $display(" outcome=%0d, got found=%0d offset=%0d kind=%0d outcome=%0d",
                                     expected.outcome, observed.found, observed.match_offset,
                                     observed.match_kind, observed.outcome);
                        end
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                if (walk_option_byte(i_in_data[7:0], i_in_first, i_in_data[15:8], i_in_final,
                                     expected))
                    expected_results.push_back(expected);
            end

            o_pending <= expected_results.size();
            o_errors  <= failures;
        end
    end

endmodule

// File: bench/tb_tcp_option_kind_search.sv
module tb_tcp_option_kind_search;
    import tcpoks_pkg::*;

    localparam int          IDLE_LIMIT      = 500;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int unsigned ITEMS_PER_PHASE = 285;
    localparam int          PHASES          = 5;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;  // option_byte, area_length
    logic                  s_axis_tuser  = 1'b0;  // first_byte
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;  // found, match_offset, match_kind, outcome, fill
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int          pending;
    int          errors;
    bit          calm        = 1'b0;
    int unsigned bytes_sent  = 0;
    int unsigned quiet_cycles = 0;
    logic [7:0]  primary_kind   = PRIMARY_KIND_RESET;
    logic [7:0]  secondary_kind = SECONDARY_KIND_RESET;

    tcp_option_kind_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tcp_option_kind_search_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_first  (s_axis_tuser),
        .i_in_final  (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side stalls
    initial begin
        int unsigned stall;
        wait (i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [7:0] area,
                             input logic fin);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {area, b};
        s_axis_tuser  <= first;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // an empty area closes any open search before the block goes idle
    task automatic close_phase();
        send_byte(8'($urandom), 1'b1, 8'd0, 1'($urandom_range(0, 1)));
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_index idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_kinds(input logic [7:0] prim, input logic [7:0] sec);
        write_register(REG_PRIMARY_KIND, prim);
        write_register(REG_SECONDARY_KIND, sec);
        primary_kind   = prim;
        secondary_kind = sec;
    endtask

    function automatic logic [7:0] pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return KIND_END;
        if (r < 25)
            return KIND_NOP;
        if (r < 45)
            return primary_kind;
        if (r < 60)
            return secondary_kind;
        return 8'($urandom_range(2, 255));
    endfunction

    task automatic run_directed();
        // empty area
        send_byte(8'hFF, 1'b1, 8'd0, 1'b0);
        // clamped area, no-op then primary kind
        send_byte(KIND_NOP, 1'b1, 8'd255, 1'b0);
        send_byte(PRIMARY_KIND_RESET, 1'b0, 8'd0, 1'b0);
        send_byte(8'd4, 1'b0, 8'hFF, 1'b0);
        // secondary kind filling the whole area
        send_byte(SECONDARY_KIND_RESET, 1'b1, 8'd6, 1'b0);
        send_byte(8'd6, 1'b0, 8'd0, 1'b0);
        // end-of-list kind on the final available byte, reported as data used up
        send_byte(KIND_END, 1'b1, 8'd4, 1'b1);
        // end of list
        send_byte(KIND_NOP, 1'b1, 8'd3, 1'b0);
        send_byte(KIND_NOP, 1'b0, 8'd0, 1'b0);
        send_byte(KIND_END, 1'b0, 8'd0, 1'b0);
        // kind at the last offset
        send_byte(KIND_NOP, 1'b1, 8'd2, 1'b0);
        send_byte(8'd30, 1'b0, 8'd0, 1'b0);
        // searched kind with too short a length
        send_byte(SECONDARY_KIND_RESET, 1'b1, 8'd10, 1'b0);
        send_byte(8'd1, 1'b0, 8'd0, 1'b0);
        // length past the area
        send_byte(8'd30, 1'b1, 8'd6, 1'b0);
        send_byte(8'd7, 1'b0, 8'd0, 1'b0);
        // area used up while skipping
        send_byte(8'd30, 1'b1, 8'd4, 1'b0);
        send_byte(8'd4, 1'b0, 8'd0, 1'b0);
        send_byte(8'hAA, 1'b0, 8'd0, 1'b0);
        send_byte(8'h55, 1'b0, 8'd0, 1'b0);
        // data ends while skipping
        send_byte(8'd30, 1'b1, 8'd8, 1'b0);
        send_byte(8'd5, 1'b0, 8'd0, 1'b0);
        send_byte(8'h00, 1'b0, 8'd0, 1'b1);
        // new header while searching
        send_byte(KIND_NOP, 1'b1, 8'd10, 1'b0);
        send_byte(KIND_NOP, 1'b0, 8'd0, 1'b0);
        send_byte(KIND_NOP, 1'b1, 8'd1, 1'b0);
        // stray byte while idle
        send_byte(8'h5A, 1'b0, 8'hFF, 1'b1);
    endtask

    task automatic send_random_header();
        int unsigned r;
        int unsigned area_field;
        int unsigned span;
        int unsigned n_bytes;
        int unsigned opt_left;
        int unsigned room;
        int unsigned hi;
        int unsigned len;
        bit          need_len;
        bit          fin_last;
        logic [7:0]  b;
        r = $urandom_range(0, 99);
        if (r < 3)
            area_field = 0;
        else if (r < 85)
            area_field = $urandom_range(1, 40);
        else
            area_field = $urandom_range(41, 255);
        span = (area_field < MAX_OPTION_BYTES) ? area_field : MAX_OPTION_BYTES;
        r = $urandom_range(0, 99);
        if (span == 0)
            n_bytes = 1;
        else if (r < 65)
            n_bytes = span;
        else if (r < 85)
            n_bytes = $urandom_range(1, span);
        else
            n_bytes = span + $urandom_range(1, 4);
        fin_last = 1'($urandom_range(0, 1));
        opt_left = 0;
        need_len = 1'b0;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            if (opt_left > 0) begin
                b = 8'($urandom);
                opt_left--;
            end else if (need_len) begin
                need_len = 1'b0;
                room = (span > i - 1) ? span - (i - 1) : 0;
                hi   = (room < 12) ? room : 12;
                r    = $urandom_range(0, 99);
                if (r < 5)
                    len = $urandom_range(0, 1);
                else if (r < 10)
                    len = room + $urandom_range(1, 3);
                else if (r < 18 && room >= 2)
                    len = room;
                else if (hi < 2)
                    len = 2;
                else
                    len = $urandom_range(2, hi);
                b        = 8'(len);
                opt_left = (len >= 2) ? len - 2 : 0;
            end else begin
                b        = pick_kind();
                need_len = (b != KIND_END && b != KIND_NOP);
            end
            send_byte(b, i == 0, (i == 0) ? 8'(area_field) : 8'($urandom),
                      fin_last && (i == n_bytes - 1));
        end
    endtask

    initial begin
        logic [7:0]  prim;
        logic [7:0]  sec;
        int unsigned target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        close_phase();

        target = bytes_sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    prim = 8'd0;
                    sec  = 8'd255;
                end
                1: begin
                    prim = 8'd255;
                    sec  = 8'd0;
                end
                2: begin
                    prim = 8'($urandom_range(2, 255));
                    sec  = 8'($urandom_range(2, 255));
                end
                3: begin
                    prim = 8'd7;
                    sec  = 8'd7;
                end
                default: begin
                    prim = PRIMARY_KIND_RESET;
                    sec  = SECONDARY_KIND_RESET;
                end
            endcase
            set_kinds(prim, sec);
            target += ITEMS_PER_PHASE;
            while (bytes_sent < target) begin
                calm = ($urandom_range(0, 5) == 0);
                if ($urandom_range(0, 19) == 0) begin
                    repeat ($urandom_range(1, 2))
                        send_byte(8'($urandom), 1'b0, 8'($urandom), 1'($urandom_range(0, 1)));
                end
                send_random_header();
                if ($urandom_range(0, 29) == 0)
                    wait_for_results();
            end
            calm = 1'b0;
            close_phase();
        end

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: tcp_option_kind_search.f
hw/rtl/tcpoks_pkg.sv
hw/rtl/tcpoks_cfg.sv
hw/rtl/tcpoks_walker.sv
hw/rtl/tcp_option_kind_search.sv
bench/tcp_option_kind_search_checker.sv
bench/tb_tcp_option_kind_search.sv
